// File: hw/rtl/web_text_escaper_core_assert.svh
// assertion macros used by the escaper checker
`ifndef WEB_TEXT_ESCAPER_CORE_ASSERT_SVH
`define WEB_TEXT_ESCAPER_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define WTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wte check failed");

// next-cycle implication, off during reset
`define WTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wte check failed");

// state that must hold on the cycle after reset is seen
`define WTE_ASSERT_RST(lbl, clk, rst_n, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("wte reset check failed");

`endif

// File: hw/rtl/wte_pkg.sv
// types and constants shared by the escaper modules
`default_nettype none

package wte_pkg;

  // escape mode codes (bit 1 selects url form encoding)
  localparam logic [1:0] MODE_HTML = 2'd0;
  localparam logic [1:0] MODE_ATTR = 2'd1;
  localparam logic [1:0] MODE_URL  = 2'd2;

  localparam int unsigned MAX_RUN = 6;

  // one classified item: the characters of its escaped run
  typedef struct packed {
    logic [MAX_RUN-1:0][7:0] chars;  // chars[0] goes out first
    logic [2:0]              len;    // 1 to 6
    logic                    last;   // item ends the string
  } run_desc_t;

  // upper-case hex digit for one nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = 8'("0") + {4'd0, nib};
    end else begin
      d = 8'("A") + {4'd0, nib} - 8'd10;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/wte_front.sv
// front end: mode register and classification of each byte into a run
`default_nettype none

module wte_front
  import wte_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_string_end,
  output run_desc_t       desc
);

  logic [1:0]  mode_r;
  logic        is_alnum;
  logic        is_print;
  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [3:0]  ones;
  logic [7:0]  ch_h;
  logic [7:0]  ch_t;
  logic [7:0]  ch_o;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HTML;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // character classes
  assign is_alnum = (in_byte >= "0" && in_byte <= "9") ||
                    (in_byte >= "A" && in_byte <= "Z") ||
                    (in_byte >= "a" && in_byte <= "z");
  assign is_print = (in_byte >= 8'h20) && (in_byte <= 8'h7e);

  // decimal digits: hundreds by compare, tens by reciprocal multiply
  always_comb begin
    if (in_byte >= 8'd200) begin
      hund = 2'd2;
    end else if (in_byte >= 8'd100) begin
      hund = 2'd1;
    end else begin
      hund = 2'd0;
    end
    rem       = 7'(in_byte - 8'(hund) * 8'd100);
    tens_prod = 15'(rem) * 15'd205;
    tens      = tens_prod[14:11];
    ones      = 4'(rem - 7'(tens) * 7'd10);
    ch_h      = 8'("0") + {6'd0, hund};
    ch_t      = 8'("0") + {4'd0, tens};
    ch_o      = 8'("0") + {4'd0, ones};
  end

  // build the escaped run
  always_comb begin
    desc      = '0;
    desc.last = in_string_end;
    if (mode_r[1]) begin
      if (in_byte == " ") begin
        desc.chars[0] = "+";
        desc.len      = 3'd1;
      end else if (is_alnum) begin
        desc.chars[0] = in_byte;
        desc.len      = 3'd1;
      end else begin
        desc.chars[0] = "%";
        desc.chars[1] = hex_digit(in_byte[7:4]);
        desc.chars[2] = hex_digit(in_byte[3:0]);
        desc.len      = 3'd3;
      end
    end else begin
      if (in_byte == "&") begin
        desc.chars[0] = "&";
        desc.chars[1] = "a";
        desc.chars[2] = "m";
        desc.chars[3] = "p";
        desc.chars[4] = ";";
        desc.len      = 3'd5;
      end else if (!mode_r[0] && in_byte == "<") begin
        desc.chars[0] = "&";
        desc.chars[1] = "l";
        desc.chars[2] = "t";
        desc.chars[3] = ";";
        desc.len      = 3'd4;
      end else if (mode_r[0] && in_byte == "\"") begin
        desc.chars[0] = "&";
        desc.chars[1] = "q";
        desc.chars[2] = "u";
        desc.chars[3] = "o";
        desc.chars[4] = "t";
        desc.chars[5] = ";";
        desc.len      = 3'd6;
      end else if (is_print) begin
        desc.chars[0] = in_byte;
        desc.len      = 3'd1;
      end else begin
        // numeric entity, no leading zeros
        desc.chars[0] = "&";
        desc.chars[1] = "#";
        if (in_byte >= 8'd100) begin
          desc.chars[2] = ch_h;
          desc.chars[3] = ch_t;
          desc.chars[4] = ch_o;
          desc.chars[5] = ";";
          desc.len      = 3'd6;
        end else if (in_byte >= 8'd10) begin
          desc.chars[2] = ch_t;
          desc.chars[3] = ch_o;
          desc.chars[4] = ";";
          desc.len      = 3'd5;
        end else begin
          desc.chars[2] = ch_o;
          desc.chars[3] = ";";
          desc.len      = 3'd4;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/wte_queue.sv
// short queue of classified runs between front and back
`default_nettype none

module wte_queue
  import wte_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_en,
  input  wire run_desc_t wr_data,
  output logic           q_full,
  output logic           rd_valid,
  output run_desc_t      rd_data,
  input  wire logic      rd_en
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  run_desc_t          mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_wr;
  logic               do_rd;

  assign q_full   = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/wte_back.sv
// back end: steps a run into the output register one character per cycle while that register is free
`default_nettype none

module wte_back
  import wte_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  wire run_desc_t  q_data,
  output logic            q_take,
  input  wire logic       out_pop,
  output logic            out_empty,
  output logic [7:0]      out_char,
  output logic            out_run_last,
  output logic            out_string_last
);

  run_desc_t  desc_r, desc_nxt;
  logic       busy_r, busy_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] oc_r, oc_nxt;
  logic       orl_r, orl_nxt;
  logic       osl_r, osl_nxt;
  logic       out_free;
  logic       emit;
  logic       at_last;

  assign out_free = !ov_r || out_pop;
  assign emit     = busy_r && out_free;
  assign at_last  = (idx_r == 3'(desc_r.len - 3'd1));
  assign q_take   = q_valid && (!busy_r || (emit && at_last));

  // run walker and output register
  always_comb begin
    desc_nxt = desc_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    ov_nxt   = ov_r;
    oc_nxt   = oc_r;
    orl_nxt  = orl_r;
    osl_nxt  = osl_r;
    if (emit) begin
      ov_nxt  = 1'b1;
      oc_nxt  = desc_r.chars[idx_r];
      orl_nxt = at_last;
      osl_nxt = at_last && desc_r.last;
      idx_nxt = idx_r + 3'd1;
      if (at_last) begin
        busy_nxt = 1'b0;
      end
    end else if (out_pop) begin
      ov_nxt = 1'b0;
    end
    if (q_take) begin
      desc_nxt = q_data;
      busy_nxt = 1'b1;
      idx_nxt  = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
    oc_r   <= oc_nxt;
    orl_r  <= orl_nxt;
    osl_r  <= osl_nxt;
  end

  assign out_empty       = !ov_r;
  assign out_char        = oc_r;
  assign out_run_last    = orl_r;
  assign out_string_last = osl_r;

endmodule

`default_nettype wire

// File: hw/rtl/web_text_escaper_core.sv
// top level of the html / attribute / url text escaper
//
// channel  direction  handshake         payload
// input    in         push / full       in_byte[7:0], in_string_end
// output   out        empty / pop       out_char[7:0], out_run_last, out_string_last
// config   in         cfg_we            cfg_wdata[1:0] (escape mode)
//
// one output character per cycle while the output register is free; a run is
// 1 to 6 characters long and is stepped out by the back end's character walker.
// the front classifies a byte in the cycle it is taken and queues the run;
// full rises only when QUEUE_DEPTH runs wait behind the walker.
// reset is synchronous, active low, and empties the queue and output register.
// pop low holds the current character and stalls the walker, not the queue.
`default_nettype none

module web_text_escaper_core
  import wte_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_string_end,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_char,
  output logic            out_run_last,
  output logic            out_string_last
);

  run_desc_t front_desc;
  run_desc_t q_data;
  logic      q_valid;
  logic      q_take;

  // classify incoming bytes
  wte_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_byte       (in_byte),
    .in_string_end (in_string_end),
    .desc          (front_desc)
  );

  // decouple front and back
  wte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_data  (front_desc),
    .q_full   (full),
    .rd_valid (q_valid),
    .rd_data  (q_data),
    .rd_en    (q_take)
  );

  // emit characters
  wte_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_take          (q_take),
    .out_pop         (pop),
    .out_empty       (empty),
    .out_char        (out_char),
    .out_run_last    (out_run_last),
    .out_string_last (out_string_last)
  );

endmodule

`default_nettype wire

// File: hw/rtl/wte_checker.sv
// port-level checks on the escaper top level, bound to every instance
`default_nettype none

`include "web_text_escaper_core_assert.svh"

module wte_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_char,
  input wire logic       out_run_last,
  input wire logic       out_string_last
);

  // nothing waits on the output right after reset
  `WTE_ASSERT_RST(a_rst_empty, clk, rst_n, empty)

  // escaped text is always plain ascii and never a nul
  `WTE_ASSERT_IMP(a_ascii_out, clk, rst_n, !empty,
                  !out_char[7] && (out_char != 8'h00))

  // the end of a string always closes a run
  `WTE_ASSERT_IMP(a_str_in_run, clk, rst_n, !empty && out_string_last, out_run_last)

  // a character not taken stays put
  `WTE_ASSERT_NXT(a_hold_out, clk, rst_n, !empty && !pop,
                  !empty && $stable({out_char, out_run_last, out_string_last}))

endmodule

bind web_text_escaper_core wte_checker u_wte_checker (.*);

`default_nettype wire
